// ----- hdl/assert_macros.svh -----
// assertion macros shared by the tremolo rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define SLFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication on top of the clocked form
`define SLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SLFT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- hdl/slft_pkg.sv -----
// package with constants, register codes and the sine table builder
`default_nettype none

package slft_pkg;

    localparam int DEFAULT_SAMPLE_BITS     = 24;
    localparam int DEFAULT_SINE_TABLE_BITS = 10;

    localparam int PHASE_BITS = 32;
    localparam int STEP_BITS  = 24;
    localparam int DEPTH_BITS = 16;
    localparam int CFG_BITS   = 24;
    localparam int SINE_BITS  = 15;
    localparam int GAIN_BITS  = 16;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = 24'd447392;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET      = 16'd26214;
    localparam logic [DEPTH_BITS-1:0] DEPTH_FULL       = 16'd32768;
    localparam logic [GAIN_BITS-1:0]  GAIN_ONE         = 16'd32768;

    typedef enum logic [0:0] {
        REG_PHASE_STEP = 1'b0,
        REG_DEPTH      = 1'b1
    } reg_idx_t;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] C1      = 64'd1686629713;
    localparam logic [63:0] C3      = 64'd693598668;
    localparam logic [63:0] C5      = 64'd85569306;
    localparam logic [63:0] C7      = 64'd5026995;
    localparam logic [63:0] C9      = 64'd172272;

    // odd degree-9 polynomial in q30, rounded to q15 and clamped
    function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned idx,
                                                          input int unsigned tbits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        t  = (64'(idx) * Q30_ONE) >> tbits;
        t2 = (t * t) >> 30;
        p  = C9;
        p  = C7 - ((t2 * p) >> 30);
        p  = C5 - ((t2 * p) >> 30);
        p  = C3 - ((t2 * p) >> 30);
        p  = C1 - ((t2 * p) >> 30);
        s  = (t * p) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[SINE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/slft_sine_rom.sv -----
// quarter-wave sine rom with registered read
`default_nettype none

module slft_sine_rom #(
    parameter int TABLE_BITS = slft_pkg::DEFAULT_SINE_TABLE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [TABLE_BITS:0]             addr,
    output logic      [slft_pkg::SINE_BITS-1:0]  data_reg
);
    import slft_pkg::*;

    localparam int ENTRIES = (1 << TABLE_BITS) + 1;

    logic [SINE_BITS-1:0] tab [0:ENTRIES-1];

    // entries are constants folded at elaboration
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_tab
        assign tab[i] = quarter_sine(i, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= tab[addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/slft_lane.sv -----
// one channel lane: sample times gain, registered product
`default_nettype none

module slft_lane #(
    parameter int SAMPLE_BITS = slft_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic signed [SAMPLE_BITS-1:0]          sample,
    input  wire logic        [slft_pkg::GAIN_BITS-1:0]  gain,
    output logic signed [SAMPLE_BITS+slft_pkg::GAIN_BITS:0] prod_reg
);
    import slft_pkg::*;

    logic signed [GAIN_BITS:0]             gain_s;
    logic signed [SAMPLE_BITS+GAIN_BITS:0] prod_next;

    assign gain_s    = $signed({1'b0, gain});
    assign prod_next = (SAMPLE_BITS + GAIN_BITS + 1)'(sample * gain_s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sine_lfo_tremolo.sv -----
// stereo tremolo: sine lfo gain applied to left and right lanes
// an accepted word moves through the rom, depth, lane and output registers in turn to m_tdata
// throughput: one word per cycle; the whole pipeline stalls while an output word waits on m_tready
// a rom read, a depth multiply, one multiply per lane and the output register set the four stages
// reset clears the lfo phase, the valid bits and loads the register defaults
`default_nettype none
`include "assert_macros.svh"

module sine_lfo_tremolo #(
    parameter int SAMPLE_BITS     = slft_pkg::DEFAULT_SAMPLE_BITS,
    parameter int SINE_TABLE_BITS = slft_pkg::DEFAULT_SINE_TABLE_BITS,
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [TDATA_W-1:0]               s_tdata,   // left_in, right_in
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [TDATA_W-1:0]               m_tdata,   // left_out, right_out
    input  wire logic                             cfg_we,
    input  wire slft_pkg::reg_idx_t               cfg_addr,
    input  wire logic [slft_pkg::CFG_BITS-1:0]    cfg_wdata
);
    import slft_pkg::*;

    localparam int TB   = SINE_TABLE_BITS;
    localparam int PW   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic [TB:0] TAB_N = (TB + 1)'(1) << TB;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [DEPTH_BITS-1:0] depth_reg;

    logic adv;
    logic acc;

    // stage 1: rom read
    logic [TB-1:0]          k;
    logic [TB:0]            rom_addr;
    logic [SINE_BITS-1:0]   rom_data;
    logic                   v1_reg;
    logic                   neg1_reg;
    logic signed [SAMPLE_BITS-1:0] left1_reg;
    logic signed [SAMPLE_BITS-1:0] right1_reg;

    // stage 2: depth times unipolar sine
    logic signed [SINE_BITS+1:0] sine_s;
    logic [SINE_BITS+1:0]        usum;
    logic [SINE_BITS-1:0]        uni;
    logic [DEPTH_BITS-1:0]       depth_sat;
    logic [DEPTH_BITS+SINE_BITS-1:0] dmul_next;
    logic [DEPTH_BITS+SINE_BITS-1:0] dmul_reg;
    logic                        v2_reg;
    logic signed [SAMPLE_BITS-1:0] left2_reg;
    logic signed [SAMPLE_BITS-1:0] right2_reg;

    // stage 3: lanes
    logic [GAIN_BITS-1:0]   gain;
    logic                   v3_reg;
    logic signed [PW-1:0]   left_prod;
    logic signed [PW-1:0]   right_prod;

    // stage 4: merge into output word
    logic                   m_tvalid_reg;
    logic [TDATA_W-1:0]     m_tdata_reg;
    logic [TDATA_W-1:0]     m_tdata_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign acc      = s_tvalid && adv;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= PHASE_STEP_RESET;
            depth_reg <= DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PHASE_STEP: step_reg  <= cfg_wdata[STEP_BITS-1:0];
                REG_DEPTH:      depth_reg <= cfg_wdata[DEPTH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_reg + PHASE_BITS'(step_reg);
        end
    end

    // odd quadrants read the table mirrored
    assign k        = phase_reg[PHASE_BITS-3 -: TB];
    assign rom_addr = phase_reg[PHASE_BITS-2] ? (TAB_N - {1'b0, k}) : {1'b0, k};

    slft_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .clk      (clk),
        .en       (adv),
        .addr     (rom_addr),
        .data_reg (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg       <= acc;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg1_reg   <= phase_reg[PHASE_BITS-1];
            left1_reg  <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            right1_reg <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            dmul_reg   <= dmul_next;
            left2_reg  <= left1_reg;
            right2_reg <= right1_reg;
            if (v3_reg)
            begin
                m_tdata_reg <= m_tdata_next;
            end
        end
    end

    // map signed sine to 0..32767
    assign sine_s    = neg1_reg ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});
    assign usum      = $unsigned(sine_s) + (SINE_BITS + 2)'(DEPTH_FULL);
    assign uni       = usum[SINE_BITS:1];
    assign depth_sat = (depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg;
    assign dmul_next = (DEPTH_BITS + SINE_BITS)'(depth_sat * uni);

    assign gain = GAIN_ONE - GAIN_BITS'(dmul_reg >> SINE_BITS);

    slft_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk      (clk),
        .en       (adv),
        .sample   (left2_reg),
        .gain     (gain),
        .prod_reg (left_prod)
    );

    slft_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk      (clk),
        .en       (adv),
        .sample   (right2_reg),
        .gain     (gain),
        .prod_reg (right_prod)
    );

    // floor divide by 2^15 is an arithmetic shift, keep the low sample bits
    assign m_tdata_next = TDATA_W'({right_prod[SAMPLE_BITS+14:15],
                                    left_prod[SAMPLE_BITS+14:15]});

    `SLFT_ASSERT_NEXT(a_phase_step, acc, phase_reg == $past(phase_reg) + PHASE_BITS'($past(step_reg)), "phase did not advance by step on accept")
    `SLFT_ASSERT_NEXT(a_phase_hold, !acc, $stable(phase_reg), "phase moved without an accepted word")
    `SLFT_ASSERT(a_dmul_range, !v2_reg || !dmul_reg[DEPTH_BITS+SINE_BITS-1], "depth product out of range")
    `SLFT_ASSERT(a_out_from_pipe, !$rose(m_tvalid_reg) || $past(v3_reg), "output valid without a word in the last stage")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for sine_lfo_tremolo: stream stimulus, gain predictor and word checks
`default_nettype none

module tb;

    localparam int          TABLE_BITS  = 10;
    localparam int          TAB_N       = 1 << TABLE_BITS;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PRINT_LIMIT = 40;
    localparam logic [23:0] STEP_AT_RST = 24'd447392;
    localparam logic [15:0] DEPTH_AT_RST = 16'd26214;

    // q30 coefficients of the odd sine polynomial
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026995;
    localparam longint unsigned K9 = 64'd172272;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
    } frame_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        slft_pkg::reg_idx_t addr;
        logic [23:0]        cfg_val;
        logic [23:0]        left;
        logic [23:0]        right;
        logic [23:0]        left_want;
        logic [23:0]        right_want;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata   = '0;    // left_in, right_in
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [47:0]        m_tdata;           // left_out, right_out
    logic               cfg_we    = 1'b0;
    slft_pkg::reg_idx_t cfg_addr  = slft_pkg::REG_PHASE_STEP;
    logic [23:0]        cfg_wdata = '0;

    // predictor state
    int          sine_q [0:TAB_N];
    logic [31:0] lfo_acc;
    logic [23:0] step_reg;
    logic [15:0] depth_reg;

    frame_t pending_frames[$];
    int     err_cnt   = 0;
    int     cycle_cnt = 0;
    bit     gap_on    = 1'b1;
    bit     stall_on  = 1'b1;

    // depth 0 passes samples through unchanged, so those rows carry typed results
    dir_row_t dir_rows [0:23] = '{
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h000000, 24'h000000, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h7fffff, 24'h800000, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'hffffff, 24'h000001, 24'h0, 24'h0},
        '{ROW_CFG,   slft_pkg::REG_DEPTH,      24'h000000, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_KNOWN, slft_pkg::REG_PHASE_STEP, 24'h0, 24'h7fffff, 24'h800000,
          24'h7fffff, 24'h800000},
        '{ROW_KNOWN, slft_pkg::REG_PHASE_STEP, 24'h0, 24'h800000, 24'h7fffff,
          24'h800000, 24'h7fffff},
        '{ROW_KNOWN, slft_pkg::REG_PHASE_STEP, 24'h0, 24'hffffff, 24'h000000,
          24'hffffff, 24'h000000},
        '{ROW_KNOWN, slft_pkg::REG_PHASE_STEP, 24'h0, 24'h555555, 24'haaaaaa,
          24'h555555, 24'haaaaaa},
        '{ROW_CFG,   slft_pkg::REG_PHASE_STEP, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_CFG,   slft_pkg::REG_DEPTH,      24'h008000, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h7fffff, 24'h7fffff, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h800000, 24'h800000, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'hffffff, 24'h7fffff, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h000001, 24'h800000, 24'h0, 24'h0},
        // depth above full saturates
        '{ROW_CFG,   slft_pkg::REG_DEPTH,      24'h00ffff, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h7fffff, 24'h800000, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h800000, 24'h7fffff, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h123456, 24'hedcba9, 24'h0, 24'h0},
        '{ROW_CFG,   slft_pkg::REG_PHASE_STEP, 24'h000000, 24'h0, 24'h0, 24'h0, 24'h0},
        // upper write bits are dropped for depth
        '{ROW_CFG,   slft_pkg::REG_DEPTH,      24'h12c001, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h7fffff, 24'h800000, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'hffffff, 24'h000001, 24'h0, 24'h0},
        '{ROW_CFG,   slft_pkg::REG_PHASE_STEP, 24'h654321, 24'h0, 24'h0, 24'h0, 24'h0},
        '{ROW_WORD,  slft_pkg::REG_PHASE_STEP, 24'h0, 24'h400000, 24'hc00000, 24'h0, 24'h0}
    };

    sine_lfo_tremolo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // first quadrant of the sine in q15, horner form in q30
    function automatic int quarter_wave(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        x   = longint'(idx) << (30 - TABLE_BITS);
        x2  = (x * x) >> 30;
        acc = K9;
        acc = K7 - ((x2 * acc) >> 30);
        acc = K5 - ((x2 * acc) >> 30);
        acc = K3 - ((x2 * acc) >> 30);
        acc = K1 - ((x2 * acc) >> 30);
        acc = (x * acc) >> 30;
        acc = (acc + 64'd16384) >> 15;
        return (acc > 64'd32767) ? 32767 : int'(acc);
    endfunction

    // gain from the current phase applied to both lanes, then the phase moves on
    function automatic frame_t scale_frame(input logic [23:0] l, input logic [23:0] r);
        frame_t      f;
        int unsigned k;
        int          s;
        int unsigned u;
        int unsigned d;
        int unsigned g;
        longint      pl;
        longint      pr;
        k = lfo_acc[29:30-TABLE_BITS];
        s = lfo_acc[30] ? sine_q[TAB_N - k] : sine_q[k];
        if (lfo_acc[31])
        begin
            s = -s;
        end
        u  = (s + 32768) >> 1;
        d  = (depth_reg > 16'd32768) ? 32768 : int'(depth_reg);
        g  = 32768 - ((d * u) >> 15);
        pl = longint'(signed'(l)) * longint'(g);
        pr = longint'(signed'(r)) * longint'(g);
        pl = pl >>> 15;
        pr = pr >>> 15;
        f.left  = pl[23:0];
        f.right = pr[23:0];
        lfo_acc = lfo_acc + {8'd0, step_reg};
        return f;
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 24'h7fffff;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
        begin
            $display("mismatch %s: got %h want %h", what, got, want);
        end
    endtask

    // present one word after a random gap and return at the accepting edge
    task automatic send_word(input logic [23:0] l, input logic [23:0] r);
        int gap;
        gap = gap_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input slft_pkg::reg_idx_t addr, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        if (addr == slft_pkg::REG_PHASE_STEP)
        begin
            step_reg = val;
        end
        else
        begin
            depth_reg = val[15:0];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // output side: random stall before each word
    initial
    begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = stall_on ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_frames.size() == 0)
            begin
                note_mismatch("unexpected word", m_tdata[23:0], 24'h0);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (m_tdata[23:0] !== want.left)
                begin
                    note_mismatch("left_out", m_tdata[23:0], want.left);
                end
                if (m_tdata[47:24] !== want.right)
                begin
                    note_mismatch("right_out", m_tdata[47:24], want.right);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        frame_t      f;
        logic [23:0] l;
        logic [23:0] r;
        logic [23:0] v;
        for (int i = 0; i <= TAB_N; i++)
        begin
            sine_q[i] = quarter_wave(i);
        end
        lfo_acc   = '0;
        step_reg  = STEP_AT_RST;
        depth_reg = DEPTH_AT_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain();
                cfg_write(dir_rows[i].addr, dir_rows[i].cfg_val);
            end
            else
            begin
                send_word(dir_rows[i].left, dir_rows[i].right);
                f = scale_frame(dir_rows[i].left, dir_rows[i].right);
                if (dir_rows[i].kind == ROW_KNOWN)
                begin
                    f.left  = dir_rows[i].left_want;
                    f.right = dir_rows[i].right_want;
                end
                pending_frames.push_back(f);
            end
        end

        for (int p = 0; p < 10; p++)
        begin
            drain();
            case ($urandom_range(0, 4))
                0:       v = 24'h000000;
                1:       v = 24'hffffff;
                2:       v = 24'($urandom_range(0, 4095));
                default: v = 24'($urandom);
            endcase
            cfg_write(slft_pkg::REG_PHASE_STEP, v);
            case ($urandom_range(0, 5))
                0:       v = 24'h000000;
                1:       v = 24'h008000;
                2:       v = 24'($urandom_range(32769, 65535));
                3:       v = 24'($urandom);
                4:       v = {8'd0, DEPTH_AT_RST};
                default: v = 24'($urandom_range(0, 32768));
            endcase
            cfg_write(slft_pkg::REG_DEPTH, v);
            // some phases run with one side or both never idling
            gap_on   = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            repeat (113)
            begin
                l = pick_sample();
                r = pick_sample();
                send_word(l, r);
                pending_frames.push_back(scale_frame(l, r));
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/slft_pkg.sv
hdl/slft_sine_rom.sv
hdl/slft_lane.sv
hdl/sine_lfo_tremolo.sv
tb/sv/tb.sv
